// ===== rtl/core/dlbh_pkg.sv =====
// Shared types, constants and helpers for the dual-lane byte hash.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package dlbh_pkg;

    localparam logic [63:0] LANE_A_INIT  = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] LANE_B_INIT  = FNV_PRIME ^ GOLDEN_GAMMA;
    localparam logic [63:0] LANE_B_MULT  = 64'd14029467366897019727;
    localparam logic [4:0]  POS_MODULUS  = 5'd31;
    localparam int          LANE_B_SHIFT = 29;
    localparam logic [5:0]  MIX_ONE_ROT  = 6'd17;
    localparam logic [5:0]  MIX_TWO_ROT  = 6'd41;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_end;
        logic       message_start;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_lane_a;
        logic [63:0] digest_lane_b;
        logic [63:0] digest_mix_one;
        logic [63:0] digest_mix_two;
    } out_item_t;

    // Decoded command handed from the front end to the hash engine.
    typedef struct packed {
        logic       restore;
        logic [7:0] data_byte;
        logic       restart_pos;
        logic       emit;
    } cmd_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_A_LO,
        ENG_A_CR1,
        ENG_A_CR2,
        ENG_B_PREP,
        ENG_B_LO,
        ENG_B_CR1,
        ENG_B_CR2
    } eng_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
        logic [6:0] inv;
        inv = 7'd64 - {1'b0, amt};
        if (amt == 6'd0) begin
            return v;
        end
        return (v << amt) | (v >> inv);
    endfunction

endpackage

// ===== rtl/core/dlbh_front.sv =====
// Front end of the hash: accepts input items, decodes their flags into
// engine commands and buffers them in a small queue. Depends on dlbh_pkg.
`timescale 1ns / 1ps

module dlbh_front #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dlbh_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output dlbh_pkg::cmd_t    cmd
);
    import dlbh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            queue_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;
    cmd_t            decoded;

    always_comb begin
        decoded.restore     = s_data.message_start;
        decoded.data_byte   = s_data.data_byte;
        decoded.restart_pos = s_data.segment_end;
        decoded.emit        = s_data.message_end;
    end

    assign s_ready   = (count_reg != CW'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Pointers wrap at the last entry, so any queue depth works.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/core/dlbh_engine.sv =====
// Back end of the hash: holds both lanes and the segment position, runs the
// two 64-bit multiplies on one shared 32x32 multiplier and registers the
// digest. Depends on dlbh_pkg.
`timescale 1ns / 1ps

module dlbh_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dlbh_pkg::cmd_t      cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output dlbh_pkg::out_item_t m_data
);
    import dlbh_pkg::*;

    eng_state_t  state_reg;
    eng_state_t  state_next;
    logic [63:0] lane_a_reg;
    logic [63:0] lane_a_next;
    logic [63:0] lane_b_reg;
    logic [63:0] lane_b_next;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [63:0] mul_x_reg;
    logic [63:0] mul_x_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;
    logic [31:0] acc_sum;
    logic [63:0] mul_result;
    logic [63:0] lane_a_base;
    logic [4:0]  pos_eff;
    logic [4:0]  pos_inc;
    logic [63:0] b_new;

    // The 64-bit low product is built from the low-by-low product plus the
    // two cross terms, of which only the low 32 bits matter.
    assign prod       = op_x * op_y;
    assign acc_sum    = acc_reg[63:32] + prod[31:0];
    assign mul_result = {acc_sum, acc_reg[31:0]};
    assign b_new      = mul_result ^ (mul_result >> LANE_B_SHIFT);

    assign lane_a_base = cmd.restore ? LANE_A_INIT : lane_a_reg;
    assign pos_eff     = (pos_reg >= POS_MODULUS) ? 5'd0 : pos_reg;
    assign pos_inc     = pos_eff + 5'd1;

    always_comb begin
        state_next     = state_reg;
        lane_a_next    = lane_a_reg;
        lane_b_next    = lane_b_reg;
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        mul_x_next     = mul_x_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        cmd_ready      = 1'b0;
        op_x           = '0;
        op_y           = '0;
        unique case (state_reg)
            ENG_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next = cmd;
                    if (cmd.restore) begin
                        lane_a_next = LANE_A_INIT;
                        lane_b_next = LANE_B_INIT;
                        pos_next    = '0;
                    end
                    mul_x_next = lane_a_base ^ {56'd0, cmd.data_byte};
                    state_next = ENG_A_LO;
                end
            end
            ENG_A_LO: begin
                op_x       = mul_x_reg[31:0];
                op_y       = FNV_PRIME[31:0];
                acc_next   = prod;
                state_next = ENG_A_CR1;
            end
            ENG_A_CR1: begin
                op_x       = mul_x_reg[31:0];
                op_y       = FNV_PRIME[63:32];
                acc_next   = mul_result;
                state_next = ENG_A_CR2;
            end
            ENG_A_CR2: begin
                op_x        = mul_x_reg[63:32];
                op_y        = FNV_PRIME[31:0];
                lane_a_next = mul_result;
                state_next  = ENG_B_PREP;
            end
            ENG_B_PREP: begin
                mul_x_next = lane_b_reg ^ rotl64(lane_a_reg + {56'd0, cmd_reg.data_byte},
                                                 {1'b0, pos_inc});
                if (cmd_reg.restart_pos || pos_inc >= POS_MODULUS) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc;
                end
                state_next = ENG_B_LO;
            end
            ENG_B_LO: begin
                op_x       = mul_x_reg[31:0];
                op_y       = LANE_B_MULT[31:0];
                acc_next   = prod;
                state_next = ENG_B_CR1;
            end
            ENG_B_CR1: begin
                op_x       = mul_x_reg[31:0];
                op_y       = LANE_B_MULT[63:32];
                acc_next   = mul_result;
                state_next = ENG_B_CR2;
            end
            ENG_B_CR2: begin
                op_x = mul_x_reg[63:32];
                op_y = LANE_B_MULT[31:0];
                // A digest waits here while the previous one is still unread.
                if (!(cmd_reg.emit && out_valid_reg && !m_ready)) begin
                    lane_b_next = b_new;
                    if (cmd_reg.emit) begin
                        out_valid_next               = 1'b1;
                        out_data_next.digest_lane_a  = lane_a_reg;
                        out_data_next.digest_lane_b  = b_new;
                        out_data_next.digest_mix_one = lane_a_reg ^ rotl64(b_new, MIX_ONE_ROT);
                        out_data_next.digest_mix_two = b_new ^ rotl64(lane_a_reg, MIX_TWO_ROT);
                    end
                    state_next = ENG_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ENG_IDLE;
            lane_a_reg    <= LANE_A_INIT;
            lane_b_reg    <= LANE_B_INIT;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lane_a_reg    <= lane_a_next;
            lane_b_reg    <= lane_b_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        mul_x_reg    <= mul_x_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/core/dual_lane_byte_hash_top.sv =====
// Top level of the dual-lane byte hash: front-end command queue plus the
// hash engine. Depends on dlbh_pkg, dlbh_front and dlbh_engine.
`timescale 1ns / 1ps

// Each input item absorbs one byte into two 64-bit lanes; an item with
// message_end set produces one digest item of four 64-bit words, other items
// produce none. Per byte the engine fetches the command, then runs the lane A
// multiply, the lane B rotate step and the dependent lane B multiply, each
// multiply as a low product plus two cross terms on its single shared 32x32
// multiplier. The input queue holds QUEUE_DEPTH items, so bytes are taken at
// full speed until it fills; a digest sits in an output register and only
// stalls the engine if the next digest is ready before the previous is taken.
module dual_lane_byte_hash_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dlbh_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dlbh_pkg::out_item_t m_data
);
    import dlbh_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    dlbh_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    dlbh_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/dlbh_checker.sv =====
// Port-level checks for the dual-lane byte hash, bound to its top level.
// Depends on dlbh_pkg and dual_lane_byte_hash_top.
`timescale 1ns / 1ps

module dlbh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input dlbh_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input dlbh_pkg::out_item_t m_data
);
    import dlbh_pkg::*;

    // A digest that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("digest item dropped or changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("digest valid after reset");

    // Reset empties the queue, so the block can take an item right away.
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // A refused input item means the queue is full, which needs prior pushes.
    a_full_needs_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("queue filled without an accepted item");

endmodule

bind dual_lane_byte_hash_top dlbh_checker u_dlbh_checker (.*);
